### rtl/true_strength_index_macros.svh
// assertion macros for the true strength index block
`ifndef TRUE_STRENGTH_INDEX_MACROS_SVH
`define TRUE_STRENGTH_INDEX_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TSI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tsi check failed");
// antecedent implies consequent in the next cycle
`define TSI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tsi check failed");
`else
`define TSI_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TSI_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/tsi_pkg.sv
`timescale 1ns / 1ps

package tsi_pkg;

    // field and register widths
    localparam int PRICE_W   = 32;
    localparam int PERIOD_W  = 12;
    localparam int OUT_W     = 15;
    localparam int CFG_IDX_W = 1;

    // fixed point: averages are signed q40.16
    localparam int FRAC_BITS = 16;
    localparam int AVG_W     = 56;
    localparam int AVG_N     = 4;
    localparam int MOM_W     = PRICE_W + 1;
    localparam int MQ_W      = MOM_W + FRAC_BITS;
    localparam int DIFF_W    = AVG_W + 1;
    localparam int ALPHA_W   = FRAC_BITS + 1;
    localparam int DL_W      = 32;
    localparam int DH_W      = DIFF_W - DL_W;
    localparam int PLO_W     = DL_W + ALPHA_W;
    localparam int PHI_W     = DH_W + ALPHA_W + 1;
    localparam int SUM_W     = PHI_W + FRAC_BITS + 1;

    // divider
    localparam int DIV_W     = 70;
    localparam int QUO_W     = ALPHA_W;
    localparam int CNT_W     = 5;
    localparam int D_W       = PERIOD_W + 1;
    localparam int ALPHA_NUM = 131072;
    localparam int ALPHA_STEPS = ALPHA_W;
    localparam int TSI_SHIFT = DIV_W - AVG_W;
    localparam int TSI_STEPS = TSI_SHIFT + 1;

    // output scaling
    localparam int OUT_SCALE = 10000;
    localparam int SCALE_W   = 14;

    // reset values
    localparam int LONG_PERIOD_RST  = 25;
    localparam int SHORT_PERIOD_RST = 13;
    localparam int ALPHA_LONG_RST =
        (ALPHA_NUM + (LONG_PERIOD_RST + 1) / 2) / (LONG_PERIOD_RST + 1);
    localparam int ALPHA_SHORT_RST =
        (ALPHA_NUM + (SHORT_PERIOD_RST + 1) / 2) / (SHORT_PERIOD_RST + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 1'd1;

    // average slots, in update order
    localparam logic [1:0] AVG_LONG_MOM  = 2'd0;
    localparam logic [1:0] AVG_LONG_ABS  = 2'd1;
    localparam logic [1:0] AVG_SHORT_MOM = 2'd2;
    localparam logic [1:0] AVG_SHORT_ABS = 2'd3;

    typedef enum logic [1:0] {
        DIV_ALPHA_LONG,
        DIV_ALPHA_SHORT,
        DIV_TSI
    } div_mode_t;

    // controller to datapath
    typedef struct packed {
        logic      take_price;
        logic      store_first;
        logic      store_prev;
        logic      seed;
        logic      do_diff;
        logic      do_mul;
        logic      do_upd;
        logic [1:0] op;
        logic      div_start;
        div_mode_t div_mode;
        logic      alpha_commit;
        logic      out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
    } stat_t;

endpackage

### rtl/tsi_div.sv
`timescale 1ns / 1ps

module tsi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [tsi_pkg::DIV_W-1:0]   num,
    input  logic [tsi_pkg::DIV_W-1:0]   den_sh,
    input  logic [tsi_pkg::CNT_W-1:0]   steps,
    output logic                        busy,
    output logic [tsi_pkg::QUO_W-1:0]   quo
);

    logic [tsi_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [tsi_pkg::DIV_W-1:0] dsh_reg;
    logic [tsi_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [tsi_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      fits;

    // one restoring step: one quotient bit per cycle
    always_comb begin
        fits     = rem_reg >= dsh_reg;
        rem_next = fits ? rem_reg - dsh_reg : rem_reg;
        quo_next = {quo_reg[tsi_pkg::QUO_W-2:0], fits};
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - tsi_pkg::CNT_W'(1);
            if (cnt_reg == tsi_pkg::CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder, shifted divisor, quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= den_sh;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

### rtl/tsi_dp.sv
`timescale 1ns / 1ps

module tsi_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsi_pkg::PERIOD_W-1:0]      cfg_wdata,
    input  logic [tsi_pkg::PRICE_W-1:0]       s_price,
    input  tsi_pkg::cmd_t                     cmd,
    output tsi_pkg::stat_t                    stat,
    output logic signed [tsi_pkg::OUT_W-1:0]  m_tsi_value
);

    logic [tsi_pkg::PERIOD_W-1:0]       long_period_reg, short_period_reg;
    logic [tsi_pkg::ALPHA_W-1:0]        alpha_long_reg, alpha_short_reg;
    logic [tsi_pkg::PRICE_W-1:0]        price_reg, prev_price_reg;
    logic signed [tsi_pkg::AVG_W-1:0]   avg_reg [tsi_pkg::AVG_N];
    logic signed [tsi_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic [tsi_pkg::PLO_W-1:0]          plo_reg, plo_next;
    logic signed [tsi_pkg::PHI_W-1:0]   phi_reg, phi_next;
    logic signed [tsi_pkg::OUT_W-1:0]   out_reg, out_next;

    logic signed [tsi_pkg::MOM_W-1:0]   mom, mom_abs;
    logic signed [tsi_pkg::DIFF_W-1:0]  mq_x, aq_x, x_sel;
    logic signed [tsi_pkg::AVG_W-1:0]   avg_sel, upd_avg;
    logic [tsi_pkg::ALPHA_W-1:0]        alpha_sel;
    logic [tsi_pkg::DL_W-1:0]           dl;
    logic [tsi_pkg::DH_W-1:0]           dh;
    logic signed [tsi_pkg::PHI_W-1:0]   dh_x, alpha_x;
    logic signed [tsi_pkg::SUM_W-1:0]   avg_sx, phi_sh, plo_sh, sum;

    logic [tsi_pkg::PERIOD_W-1:0]       period_sel, period_eff;
    logic [tsi_pkg::D_W-1:0]            d;
    logic [tsi_pkg::AVG_W-1:0]          mag, den;
    logic [tsi_pkg::DIV_W-1:0]          div_num, div_den;
    logic [tsi_pkg::CNT_W-1:0]          div_steps;
    logic                               div_busy;
    logic [tsi_pkg::QUO_W-1:0]          quo;
    logic [tsi_pkg::SCALE_W-1:0]        q_sat;
    logic signed [tsi_pkg::OUT_W-1:0]   q_val;
    logic                               den_ok;

    // period registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_period_reg  <= tsi_pkg::PERIOD_W'(tsi_pkg::LONG_PERIOD_RST);
            short_period_reg <= tsi_pkg::PERIOD_W'(tsi_pkg::SHORT_PERIOD_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                tsi_pkg::CFG_LONG:  long_period_reg  <= cfg_wdata;
                tsi_pkg::CFG_SHORT: short_period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // smoothing factors, recomputed by the divider after a period write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_long_reg  <= tsi_pkg::ALPHA_W'(tsi_pkg::ALPHA_LONG_RST);
            alpha_short_reg <= tsi_pkg::ALPHA_W'(tsi_pkg::ALPHA_SHORT_RST);
        end else if (cmd.alpha_commit) begin
            case (cmd.div_mode)
                tsi_pkg::DIV_ALPHA_LONG:  alpha_long_reg  <= quo;
                tsi_pkg::DIV_ALPHA_SHORT: alpha_short_reg <= quo;
                default: ;
            endcase
        end
    end

    // momentum and its magnitude, scaled into q33.16
    always_comb begin
        mom     = $signed({1'b0, price_reg}) - $signed({1'b0, prev_price_reg});
        mom_abs = mom[tsi_pkg::MOM_W-1] ? -mom : mom;
        mq_x    = {{(tsi_pkg::DIFF_W-tsi_pkg::MQ_W){mom[tsi_pkg::MOM_W-1]}},
                   mom, {tsi_pkg::FRAC_BITS{1'b0}}};
        aq_x    = {{(tsi_pkg::DIFF_W-tsi_pkg::MQ_W){mom_abs[tsi_pkg::MOM_W-1]}},
                   mom_abs, {tsi_pkg::FRAC_BITS{1'b0}}};
    end

    // operand selection for the current average
    always_comb begin
        avg_sel = avg_reg[cmd.op];
        case (cmd.op)
            tsi_pkg::AVG_LONG_MOM: x_sel = mq_x;
            tsi_pkg::AVG_LONG_ABS: x_sel = aq_x;
            tsi_pkg::AVG_SHORT_MOM: begin
                x_sel = {avg_reg[tsi_pkg::AVG_LONG_MOM][tsi_pkg::AVG_W-1],
                         avg_reg[tsi_pkg::AVG_LONG_MOM]};
            end
            tsi_pkg::AVG_SHORT_ABS: begin
                x_sel = {avg_reg[tsi_pkg::AVG_LONG_ABS][tsi_pkg::AVG_W-1],
                         avg_reg[tsi_pkg::AVG_LONG_ABS]};
            end
            default: x_sel = mq_x;
        endcase
        // short averages sit in the upper half of the slots
        alpha_sel = cmd.op[1] ? alpha_short_reg : alpha_long_reg;
        diff_next = x_sel - {avg_sel[tsi_pkg::AVG_W-1], avg_sel};
    end

    // split product: low 32 bits unsigned, high part signed
    always_comb begin
        dl       = diff_reg[tsi_pkg::DL_W-1:0];
        dh       = diff_reg[tsi_pkg::DIFF_W-1:tsi_pkg::DL_W];
        plo_next = {{(tsi_pkg::PLO_W-tsi_pkg::DL_W){1'b0}}, dl}
                 * {{(tsi_pkg::PLO_W-tsi_pkg::ALPHA_W){1'b0}}, alpha_sel};
        dh_x     = {{(tsi_pkg::PHI_W-tsi_pkg::DH_W){dh[tsi_pkg::DH_W-1]}}, dh};
        alpha_x  = {{(tsi_pkg::PHI_W-tsi_pkg::ALPHA_W){1'b0}}, alpha_sel};
        phi_next = dh_x * alpha_x;
    end

    // avg + floor(diff * alpha / 2^16)
    always_comb begin
        avg_sx  = {{(tsi_pkg::SUM_W-tsi_pkg::AVG_W){avg_sel[tsi_pkg::AVG_W-1]}}, avg_sel};
        phi_sh  = {{(tsi_pkg::SUM_W-tsi_pkg::PHI_W-tsi_pkg::FRAC_BITS){phi_reg[tsi_pkg::PHI_W-1]}},
                   phi_reg, {tsi_pkg::FRAC_BITS{1'b0}}};
        plo_sh  = {{(tsi_pkg::SUM_W-tsi_pkg::PLO_W+tsi_pkg::FRAC_BITS){1'b0}},
                   plo_reg[tsi_pkg::PLO_W-1:tsi_pkg::FRAC_BITS]};
        sum     = avg_sx + phi_sh + plo_sh;
        upd_avg = sum[tsi_pkg::AVG_W-1:0];
    end

    // price, smoothing pipeline and averages
    always_ff @(posedge aclk) begin
        if (cmd.take_price) begin
            price_reg <= s_price;
        end
        if (cmd.store_first) begin
            prev_price_reg <= s_price;
        end else if (cmd.store_prev) begin
            prev_price_reg <= price_reg;
        end
        if (cmd.do_diff) begin
            diff_reg <= diff_next;
        end
        if (cmd.do_mul) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (cmd.seed) begin
            avg_reg[tsi_pkg::AVG_LONG_MOM]  <= mq_x[tsi_pkg::AVG_W-1:0];
            avg_reg[tsi_pkg::AVG_LONG_ABS]  <= aq_x[tsi_pkg::AVG_W-1:0];
            avg_reg[tsi_pkg::AVG_SHORT_MOM] <= mq_x[tsi_pkg::AVG_W-1:0];
            avg_reg[tsi_pkg::AVG_SHORT_ABS] <= aq_x[tsi_pkg::AVG_W-1:0];
        end else if (cmd.do_upd) begin
            avg_reg[cmd.op] <= upd_avg;
        end
    end

    // divider operands: factor 2/(p+1) rounded, or the scaled ratio
    always_comb begin
        period_sel = (cmd.div_mode == tsi_pkg::DIV_ALPHA_SHORT)
                   ? short_period_reg : long_period_reg;
        period_eff = (period_sel == '0) ? tsi_pkg::PERIOD_W'(1) : period_sel;
        d          = {1'b0, period_eff} + tsi_pkg::D_W'(1);
        mag        = avg_reg[tsi_pkg::AVG_SHORT_MOM][tsi_pkg::AVG_W-1]
                   ? -avg_reg[tsi_pkg::AVG_SHORT_MOM] : avg_reg[tsi_pkg::AVG_SHORT_MOM];
        den        = avg_reg[tsi_pkg::AVG_SHORT_ABS];
        case (cmd.div_mode)
            tsi_pkg::DIV_ALPHA_LONG, tsi_pkg::DIV_ALPHA_SHORT: begin
                div_num   = tsi_pkg::DIV_W'(tsi_pkg::ALPHA_NUM)
                          + {{(tsi_pkg::DIV_W-tsi_pkg::D_W){1'b0}}, d >> 1};
                div_den   = {{(tsi_pkg::DIV_W-tsi_pkg::D_W){1'b0}}, d} << tsi_pkg::FRAC_BITS;
                div_steps = tsi_pkg::CNT_W'(tsi_pkg::ALPHA_STEPS);
            end
            tsi_pkg::DIV_TSI: begin
                div_num   = {{(tsi_pkg::DIV_W-tsi_pkg::AVG_W){1'b0}}, mag}
                          * {{(tsi_pkg::DIV_W-tsi_pkg::SCALE_W){1'b0}},
                             tsi_pkg::SCALE_W'(tsi_pkg::OUT_SCALE)};
                div_den   = {den, {tsi_pkg::TSI_SHIFT{1'b0}}};
                div_steps = tsi_pkg::CNT_W'(tsi_pkg::TSI_STEPS);
            end
            default: begin
                div_num   = '0;
                div_den   = '0;
                div_steps = '0;
            end
        endcase
    end

    tsi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den_sh  (div_den),
        .steps   (div_steps),
        .busy    (div_busy),
        .quo     (quo)
    );

    // saturate, apply sign, zero when the denominator is not positive
    always_comb begin
        q_sat    = (quo > tsi_pkg::QUO_W'(tsi_pkg::OUT_SCALE))
                 ? tsi_pkg::SCALE_W'(tsi_pkg::OUT_SCALE) : quo[tsi_pkg::SCALE_W-1:0];
        q_val    = avg_reg[tsi_pkg::AVG_SHORT_MOM][tsi_pkg::AVG_W-1]
                 ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
        den_ok   = !den[tsi_pkg::AVG_W-1] && (den != '0);
        out_next = den_ok ? q_val : '0;
    end

    // output data register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign stat.div_busy = div_busy;
    assign m_tsi_value   = out_reg;

endmodule

### rtl/tsi_ctrl.sv
`timescale 1ns / 1ps

module tsi_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                           s_valid,
    output logic                           s_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tsi_pkg::cmd_t                  cmd,
    input  tsi_pkg::stat_t                 stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALPHA_WAIT,
        S_SEED,
        S_DIFF,
        S_MUL,
        S_UPD,
        S_DIV_START,
        S_DIV_WAIT,
        S_PUSH
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SEED,
        PH_RUN
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         op_reg, op_next;
    logic [1:0]         pending_reg, pending_next;
    logic [1:0]         pend_clr, pend_set;
    tsi_pkg::div_mode_t alpha_mode_reg, alpha_mode_next;
    logic               m_valid_reg, m_valid_next;
    logic               ready;
    logic               accept;
    logic               out_free;

    // a period write marks its factor for recomputation
    assign pend_set = {cfg_we && (cfg_index == tsi_pkg::CFG_SHORT),
                       cfg_we && (cfg_index == tsi_pkg::CFG_LONG)};

    assign ready    = (state_reg == S_IDLE) && (pending_reg == '0) && !cfg_we;
    assign accept   = s_valid && ready;
    assign out_free = !m_valid_reg || m_ready;

    // next state and command decode
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        op_next         = op_reg;
        alpha_mode_next = alpha_mode_reg;
        pend_clr        = '0;
        cmd             = '0;
        cmd.op          = op_reg;
        cmd.div_mode    = tsi_pkg::DIV_TSI;

        case (state_reg)
            S_IDLE: begin
                if (pending_reg[0]) begin
                    cmd.div_start   = 1'b1;
                    cmd.div_mode    = tsi_pkg::DIV_ALPHA_LONG;
                    alpha_mode_next = tsi_pkg::DIV_ALPHA_LONG;
                    pend_clr        = 2'b01;
                    state_next      = S_ALPHA_WAIT;
                end else if (pending_reg[1]) begin
                    cmd.div_start   = 1'b1;
                    cmd.div_mode    = tsi_pkg::DIV_ALPHA_SHORT;
                    alpha_mode_next = tsi_pkg::DIV_ALPHA_SHORT;
                    pend_clr        = 2'b10;
                    state_next      = S_ALPHA_WAIT;
                end else if (accept) begin
                    cmd.take_price = 1'b1;
                    case (phase_reg)
                        PH_FIRST: begin
                            cmd.store_first = 1'b1;
                            phase_next      = PH_SEED;
                        end
                        PH_SEED: begin
                            state_next = S_SEED;
                        end
                        default: begin
                            op_next    = tsi_pkg::AVG_LONG_MOM;
                            state_next = S_DIFF;
                        end
                    endcase
                end
            end
            S_ALPHA_WAIT: begin
                cmd.div_mode = alpha_mode_reg;
                if (!stat.div_busy) begin
                    cmd.alpha_commit = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_SEED: begin
                cmd.seed   = 1'b1;
                phase_next = PH_RUN;
                state_next = S_DIV_START;
            end
            S_DIFF: begin
                cmd.do_diff = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL: begin
                cmd.do_mul = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.do_upd = 1'b1;
                if (op_reg == tsi_pkg::AVG_SHORT_ABS) begin
                    state_next = S_DIV_START;
                end else begin
                    op_next    = op_reg + 2'd1;
                    state_next = S_DIFF;
                end
            end
            S_DIV_START: begin
                cmd.div_start  = 1'b1;
                cmd.store_prev = 1'b1;
                state_next     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        pending_next = (pending_reg & ~pend_clr) | pend_set;
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FIRST;
            op_reg         <= '0;
            pending_reg    <= '0;
            alpha_mode_reg <= tsi_pkg::DIV_ALPHA_LONG;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            op_reg         <= op_next;
            pending_reg    <= pending_next;
            alpha_mode_reg <= alpha_mode_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign s_ready = ready;
    assign m_valid = m_valid_reg;

endmodule

### rtl/true_strength_index.sv
// True strength index, double smoothed, one price per request.
// Input channel s_valid/s_ready carries s_price; result channel m_valid/m_ready
// carries m_tsi_value, the index in hundredths of a percent, within +/-10000.
// The first request after reset only stores the price and gives no result;
// every later request gives exactly one result.
// Sequence: the seeding request seeds the averages and goes straight to the
// divider; a running request goes through smoothing (four averages, three steps
// each on one shared multiplier pair), the bit-serial divider and sequencing,
// and the block takes no new request until its last result is loaded.
// A write on cfg_we sets a period; the matching factor is then rebuilt in the
// same divider, with s_ready low meanwhile. Periods apply from the next request
// and the averages are kept.
// Reset (aresetn low at a clock edge) restores periods 25 and 13 and restarts
// at the first-sample phase.
// The result sits in an output register: if m_ready stays low the block still
// accepts and works on the next request and holds just before delivering it.
`timescale 1ns / 1ps
`include "true_strength_index_macros.svh"

module true_strength_index (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tsi_pkg::PERIOD_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tsi_pkg::PRICE_W-1:0]       s_price,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tsi_pkg::OUT_W-1:0]  m_tsi_value
);

    tsi_pkg::cmd_t  ctrl_cmd;
    tsi_pkg::stat_t dp_stat;

    // sequencer
    tsi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat)
    );

    // averages, divider and output register
    tsi_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_price     (s_price),
        .cmd         (ctrl_cmd),
        .stat        (dp_stat),
        .m_tsi_value (m_tsi_value)
    );

    // checks
    `TSI_ASSERT_NXT(a_div_runs_after_start, aclk, aresetn, ctrl_cmd.div_start, dp_stat.div_busy)
    `TSI_ASSERT_IMP(a_no_start_while_busy, aclk, aresetn, ctrl_cmd.div_start, !dp_stat.div_busy)
    `TSI_ASSERT_IMP(a_ready_only_when_div_free, aclk, aresetn, s_ready, !dp_stat.div_busy)
    `TSI_ASSERT_IMP(a_result_in_range, aclk, aresetn, m_valid, (m_tsi_value <= 15'sd10000) && (m_tsi_value >= -15'sd10000))

endmodule
